### rtl/crc_pkg.sv
// Package for the bit-serial CRC codeword encoder.
// Holds the payload and job types, register indexes and generator helpers.
// Has no dependencies.
package crc_pkg;

  localparam int MAX_DEGREE = 32;
  localparam int DEG_W = 6;
  localparam int IDX_W = $clog2(MAX_DEGREE);
  localparam int CFG_IDX_W = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_TAPS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE = CFG_IDX_W'(1);

  localparam logic [MAX_DEGREE-1:0] TAPS_RESET = MAX_DEGREE'(32'h04C11DB7);
  localparam logic [DEG_W-1:0] DEGREE_RESET = DEG_W'(MAX_DEGREE);

  typedef struct packed {
    logic message_bit;
    logic last_bit;
  } msg_t;

  typedef struct packed {
    logic codeword_bit;
    logic is_check_bit;
    logic last_of_run;
  } code_t;

  typedef struct packed {
    logic                  msg_bit;
    logic                  last;
    logic [MAX_DEGREE-1:0] rem;
    logic [DEG_W-1:0]      deg;
  } job_t;

  typedef struct packed {
    logic push;
    logic full;
  } qctl_t;

  // Zero degree counts as one, and degrees above the maximum are clamped.
  function automatic logic [DEG_W-1:0] eff_degree(input logic [DEG_W-1:0] d);
    logic [DEG_W-1:0] r;
    r = d;
    if (d == '0) r = DEG_W'(1);
    if (d > DEG_W'(MAX_DEGREE)) r = DEG_W'(MAX_DEGREE);
    return r;
  endfunction

  function automatic logic [MAX_DEGREE-1:0] degree_mask(input logic [DEG_W-1:0] d);
    logic [MAX_DEGREE-1:0] m;
    for (int i = 0; i < MAX_DEGREE; i++) begin
      m[i] = (DEG_W'(i) < d);
    end
    return m;
  endfunction

endpackage

### rtl/crc_front.sv
// Front end of the CRC encoder: configuration registers and the remainder LFSR.
// Accepts message bits and turns each into a job for the queue. Uses crc_pkg.
module crc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          msg_valid,
  output logic                          msg_stall,
  input  crc_pkg::msg_t                 msg,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [crc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          qfull,
  output crc_pkg::qctl_t                qctl,
  output crc_pkg::job_t                 job
);
  import crc_pkg::*;

  logic [MAX_DEGREE-1:0] taps;
  logic [DEG_W-1:0]      degree;
  logic [MAX_DEGREE-1:0] rem;
  logic [MAX_DEGREE-1:0] rem_next;
  logic [DEG_W-1:0]      d;
  logic [MAX_DEGREE-1:0] mask;
  logic [MAX_DEGREE-1:0] masked;
  logic [IDX_W-1:0]      top_idx;
  logic                  fb;
  logic [MAX_DEGREE-1:0] updated;
  logic                  accept;

  assign cfg_ready = 1'b1;
  assign msg_stall = qfull;
  assign accept = msg_valid && !qfull;

  always_comb begin
    d = eff_degree(degree);
    mask = degree_mask(d);
    masked = rem & mask;
    top_idx = IDX_W'(d - DEG_W'(1));
    fb = msg.message_bit ^ masked[top_idx];
    updated = (masked << 1) & mask;
    if (fb) begin
      updated = updated ^ (taps & mask);
    end
    rem_next = msg.last_bit ? '0 : updated;
  end

  assign job.msg_bit = msg.message_bit;
  assign job.last = msg.last_bit;
  assign job.rem = updated;
  assign job.deg = d;
  assign qctl.push = accept;
  assign qctl.full = qfull;

  always_ff @(posedge clk) begin
    if (rst) begin
      taps <= TAPS_RESET;
      degree <= DEGREE_RESET;
      rem <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TAPS) begin
          taps <= MAX_DEGREE'(cfg_data);
        end else if (cfg_index == REG_DEGREE) begin
          degree <= cfg_data[DEG_W-1:0];
        end
      end
      if (accept) begin
        rem <= rem_next;
      end
    end
  end

endmodule

### rtl/crc_queue.sv
// Short job queue between the front and back ends of the CRC encoder.
// A small circular buffer of jobs with a fill count. Uses crc_pkg.
module crc_queue (
  input  logic           clk,
  input  logic           rst,
  input  crc_pkg::qctl_t qctl,
  input  crc_pkg::job_t  wr_job,
  output logic           full,
  output logic           empty,
  input  logic           pop,
  output crc_pkg::job_t  rd_job
);
  import crc_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_push = qctl.push && !qctl.full;
  assign do_pop = pop && !empty;
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10: count <= count + QCNT_W'(1);
        2'b01: count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/crc_back.sv
// Back end of the CRC encoder: emits the message bit of each job and then
// serializes the remainder of a final job, MSB first. Uses crc_pkg.
module crc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  crc_pkg::job_t  job,
  output logic           pop,
  output logic           code_valid,
  input  logic           code_stall,
  output crc_pkg::code_t code
);
  import crc_pkg::*;

  logic [DEG_W-1:0]      cnt;
  logic [MAX_DEGREE-1:0] rem_hold;
  logic [IDX_W-1:0]      bit_idx;
  logic                  advance;

  assign advance = !code_valid || !code_stall;
  assign pop = advance && (cnt == '0) && !empty;
  assign bit_idx = IDX_W'(cnt - DEG_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
      cnt <= '0;
    end else if (advance) begin
      if (cnt != '0) begin
        code_valid <= 1'b1;
        cnt <= cnt - DEG_W'(1);
      end else if (!empty) begin
        code_valid <= 1'b1;
        if (job.last) begin
          cnt <= job.deg;
        end
      end else begin
        code_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (cnt != '0) begin
        code.codeword_bit <= rem_hold[bit_idx];
        code.is_check_bit <= 1'b1;
        code.last_of_run <= (cnt == DEG_W'(1));
      end else if (!empty) begin
        code.codeword_bit <= job.msg_bit;
        code.is_check_bit <= 1'b0;
        code.last_of_run <= 1'b0;
        if (job.last) begin
          rem_hold <= job.rem;
        end
      end
    end
  end

endmodule

### rtl/crc_codeword_encoder.sv
// Bit-serial CRC codeword encoder with programmable generator and degree.
// An accepted message bit is written into the job queue, then registered as
// its codeword bit. One message bit is accepted per cycle while the queue is
// not full; a final bit keeps the output busy while the remainder is shifted
// out, and the two-entry job queue absorbs input meanwhile. Synchronous reset
// clears the remainder and queue and loads the CRC-32 generator with degree 32.
module crc_codeword_encoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          msg_valid,
  output logic                          msg_stall,
  input  crc_pkg::msg_t                 msg,
  output logic                          code_valid,
  input  logic                          code_stall,
  output crc_pkg::code_t                code,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [crc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import crc_pkg::*;

  qctl_t qctl;
  job_t  wr_job;
  job_t  rd_job;
  logic  qfull;
  logic  qempty;
  logic  pop;

  crc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .qfull     (qfull),
    .qctl      (qctl),
    .job       (wr_job)
  );

  crc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .qctl   (qctl),
    .wr_job (wr_job),
    .full   (qfull),
    .empty  (qempty),
    .pop    (pop),
    .rd_job (rd_job)
  );

  crc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (qempty),
    .job        (rd_job),
    .pop        (pop),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code       (code)
  );

endmodule
